FILE: design/clwe_pkg.sv
`default_nettype none

package clwe_pkg;

    localparam int FUNC_W = 2;
    localparam int INDEX_W = 16;
    localparam int VALUE_W = 8;
    localparam int STATUS_W = 1;

    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 16;

    localparam int CHAOS_W = 24;
    localparam int LEN_W = 17;
    localparam int RETRY_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int MAP_PROD_W = 2 * CHAOS_W + 1;
    localparam int MAP_SHIFT = 22;
    localparam int POS_PROD_W = LEN_W + CHAOS_W;

    localparam int EPOCH_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    localparam int BIT_W = 3;

    localparam logic [CHAOS_W:0] Q_ONE = 25'h1000000;
    localparam logic [VALUE_W-1:0] LSB_KEEP = 8'hfe;
    localparam logic [VALUE_W-1:0] LSB_BIT = 8'h01;

    localparam logic [CHAOS_W-1:0] SEED_RESET = 24'd167772;
    localparam logic [LEN_W-1:0] LENGTH_RESET = 17'd65536;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd4096;

    localparam logic [FUNC_W-1:0] OP_START = 2'd0;
    localparam logic [FUNC_W-1:0] OP_LOAD = 2'd1;
    localparam logic [FUNC_W-1:0] OP_EMBED = 2'd2;
    localparam logic [FUNC_W-1:0] OP_READ = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic in_range;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } clwe_entry_t;

    typedef struct packed {
        logic valid;
        clwe_entry_t entry;
    } clwe_queue_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } clwe_back_ctl_t;

    typedef struct packed {
        logic [CHAOS_W-1:0] seed;
        logic [LEN_W-1:0] length;
        logic [RETRY_W-1:0] retry_limit;
    } clwe_cfg_t;

endpackage

`default_nettype wire

FILE: design/chaotic_lsb_watermark_embed.sv
// Executor flow for a transaction taken from the queue: a start or a load is done in the idle
// state; a read passes through a read state and then the output state; an embed iteration runs
// two multiplies, one memory probe and one visited check, and skips the check when the position
// is out of range.
// Throughput is one transaction at a time through the executor; a four-entry queue in front.
// Reset clears all control state and then sweeps all IMAGE_BYTES entries of the visited map with
// s_tready low; every 255th start repeats that sweep when the run counter wraps.
`default_nettype none

module chaotic_lsb_watermark_embed #(
    parameter int IMAGE_BYTES = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [clwe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [clwe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: index[15:0], value[23:16].
    input  wire logic [clwe_pkg::IN_DATA_W-1:0]    s_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [clwe_pkg::FUNC_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0: read_value[7:0], status[8], zero padding[15:9].
    output logic [clwe_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import clwe_pkg::*;

    clwe_cfg_t cfg_reg;
    clwe_queue_t queue;
    clwe_back_ctl_t ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed <= SEED_RESET;
            cfg_reg.length <= LENGTH_RESET;
            cfg_reg.retry_limit <= RETRY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEED: cfg_reg.seed <= cfg_wdata[CHAOS_W-1:0];
                REG_LENGTH: cfg_reg.length <= cfg_wdata[LEN_W-1:0];
                REG_RETRY: cfg_reg.retry_limit <= cfg_wdata[RETRY_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    clwe_front #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .ctl(ctl),
        .queue(queue)
    );

    clwe_back #(
        .IMAGE_BYTES(IMAGE_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .queue(queue),
        .ctl(ctl),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

endmodule

`default_nettype wire

FILE: design/clwe_front.sv
`default_nettype none

module clwe_front #(
    parameter int IMAGE_BYTES = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [clwe_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic [clwe_pkg::FUNC_W-1:0]       s_tuser,
    input  wire clwe_pkg::clwe_back_ctl_t          ctl,
    output clwe_pkg::clwe_queue_t                  queue
);
    import clwe_pkg::*;

    clwe_entry_t queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0] count_reg;
    logic [QUEUE_AW:0] count_next;

    clwe_entry_t incoming;
    logic keep;
    logic push;
    logic pop;

    always_comb
    begin
        incoming.op = s_tuser;
        incoming.index = s_tdata[INDEX_W-1:0];
        incoming.value = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
        incoming.in_range = ({16'b0, incoming.index} < 32'(IMAGE_BYTES));
        // A load outside the store has no effect, so it never enters the queue.
        keep = !((incoming.op == OP_LOAD) && !incoming.in_range);
    end

    assign s_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH)) && !ctl.clearing;
    assign push = s_tvalid && s_tready && keep;
    assign pop = ctl.pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

    assign queue.valid = (count_reg != '0);
    assign queue.entry = queue_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: design/clwe_back.sv
`default_nettype none

module clwe_back #(
    parameter int IMAGE_BYTES = 65536
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire clwe_pkg::clwe_cfg_t               cfg,
    input  wire clwe_pkg::clwe_queue_t             queue,
    output clwe_pkg::clwe_back_ctl_t               ctl,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [clwe_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import clwe_pkg::*;

    localparam int AW = $clog2(IMAGE_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(IMAGE_BYTES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MAP = 3'd2;
    localparam logic [2:0] S_POS = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_CHECK = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;
    localparam logic [2:0] S_OUT = 3'd7;

    logic [VALUE_W-1:0] image_mem [IMAGE_BYTES];
    logic [EPOCH_W-1:0] visit_mem [IMAGE_BYTES];

    logic [2:0] state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [CHAOS_W-1:0] chaos_reg, chaos_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [RETRY_W-1:0] tries_reg, tries_next;
    clwe_entry_t entry_reg, entry_next;
    logic [AW-1:0] pos_addr_reg, pos_addr_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [MAP_PROD_W-1:0] map_prod_reg;
    logic [POS_PROD_W-1:0] pos_prod_reg;
    logic [VALUE_W-1:0] img_rd_reg;
    logic [EPOCH_W-1:0] vis_rd_reg;

    logic [CHAOS_W:0] one_minus_x;
    logic [MAP_PROD_W-MAP_SHIFT-1:0] map_shifted;
    logic [CHAOS_W-1:0] map_next_x;
    logic [LEN_W-1:0] pos;
    logic pos_ok;
    logic [RETRY_W:0] tries_inc;
    logic exhausted;
    logic cur_bit;
    logic out_load;

    logic img_we;
    logic [AW-1:0] img_waddr;
    logic [VALUE_W-1:0] img_wdata;
    logic [AW-1:0] img_raddr;
    logic vis_we;
    logic [AW-1:0] vis_waddr;
    logic [EPOCH_W-1:0] vis_wdata;

    assign one_minus_x = Q_ONE - {1'b0, chaos_reg};
    assign map_shifted = map_prod_reg[MAP_PROD_W-1:MAP_SHIFT];
    // The product reaches one only at x equal to one half; it saturates there.
    assign map_next_x = (|map_shifted[MAP_PROD_W-MAP_SHIFT-1:CHAOS_W]) ? '1
                                                                    : map_shifted[CHAOS_W-1:0];
    assign pos = pos_prod_reg[POS_PROD_W-1:CHAOS_W];
    assign pos_ok = (pos < cfg.length) && ({15'b0, pos} < 32'(IMAGE_BYTES));
    assign tries_inc = {1'b0, tries_reg} + 1'b1;
    assign exhausted = (tries_inc == {1'b0, cfg.retry_limit});
    assign cur_bit = entry_reg.value[bit_reg];

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        epoch_next = epoch_reg;
        chaos_next = chaos_reg;
        bit_next = bit_reg;
        tries_next = tries_reg;
        entry_next = entry_reg;
        pos_addr_next = pos_addr_reg;
        res_value_next = res_value_reg;
        res_status_next = res_status_reg;
        out_load = 1'b0;
        ctl.pop = 1'b0;
        ctl.clearing = (state_reg == S_CLEAR);
        img_we = 1'b0;
        img_waddr = pos_addr_reg;
        img_wdata = (img_rd_reg & LSB_KEEP) | (LSB_BIT & {VALUE_W{cur_bit}});
        img_raddr = pos_addr_reg;
        vis_we = 1'b0;
        vis_waddr = pos_addr_reg;
        vis_wdata = epoch_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                vis_we = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = '0;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                img_raddr = AW'(queue.entry.index);
                if (queue.valid)
                begin
                    ctl.pop = 1'b1;
                    entry_next = queue.entry;
                    unique case (queue.entry.op)
                        OP_START:
                        begin
                            chaos_next = cfg.seed;
                            // Epoch zero marks a cleared entry; on wrap the map is swept.
                            if (epoch_reg == '1)
                            begin
                                epoch_next = EPOCH_W'(1);
                                clr_next = '0;
                                state_next = S_CLEAR;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                        OP_LOAD:
                        begin
                            img_we = 1'b1;
                            img_waddr = AW'(queue.entry.index);
                            img_wdata = queue.entry.value;
                        end
                        OP_EMBED:
                        begin
                            bit_next = '1;
                            tries_next = '0;
                            res_value_next = '0;
                            if (cfg.retry_limit == '0)
                            begin
                                res_status_next = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_MAP;
                            end
                        end
                        OP_READ:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_MAP:
            begin
                state_next = S_POS;
            end
            S_POS:
            begin
                chaos_next = map_next_x;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (pos_ok)
                begin
                    pos_addr_next = AW'(pos);
                    img_raddr = AW'(pos);
                    state_next = S_CHECK;
                end
                else if (exhausted)
                begin
                    res_status_next = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    tries_next = tries_inc[RETRY_W-1:0];
                    state_next = S_MAP;
                end
            end
            S_CHECK:
            begin
                if (vis_rd_reg == epoch_reg)
                begin
                    if (exhausted)
                    begin
                        res_status_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        tries_next = tries_inc[RETRY_W-1:0];
                        state_next = S_MAP;
                    end
                end
                else
                begin
                    img_we = 1'b1;
                    vis_we = 1'b1;
                    if (bit_reg == '0)
                    begin
                        res_status_next = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        bit_next = bit_reg - 1'b1;
                        tries_next = '0;
                        state_next = S_MAP;
                    end
                end
            end
            S_READ:
            begin
                res_value_next = entry_reg.in_range ? img_rd_reg : '0;
                res_status_next = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            epoch_reg <= EPOCH_W'(1);
            chaos_reg <= SEED_RESET;
            bit_reg <= '0;
            tries_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            epoch_reg <= epoch_next;
            chaos_reg <= chaos_next;
            bit_reg <= bit_next;
            tries_reg <= tries_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pos_addr_reg <= pos_addr_next;
        res_value_reg <= res_value_next;
        res_status_reg <= res_status_next;
        map_prod_reg <= MAP_PROD_W'(chaos_reg) * MAP_PROD_W'(one_minus_x);
        pos_prod_reg <= POS_PROD_W'(cfg.length) * POS_PROD_W'(map_next_x);
        if (out_load)
        begin
            out_value_reg <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            image_mem[img_waddr] <= img_wdata;
        end
        img_rd_reg <= image_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            visit_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= visit_mem[img_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {(OUT_DATA_W-VALUE_W-STATUS_W)'(0), out_status_reg, out_value_reg};

endmodule

`default_nettype wire

FILE: design/clwe_checker.sv
`default_nettype none

module clwe_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [clwe_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import clwe_pkg::*;

    // No transaction is taken while reset holds the visited-map sweep.
    assert property (@(posedge clk) !rst_n |-> !s_tready)
        else $error("input ready during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:VALUE_W+STATUS_W] == '0))
        else $error("result padding not zero");

endmodule

bind chaotic_lsb_watermark_embed clwe_checker u_clwe_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire

FILE: dv/chaotic_lsb_watermark_embed_tb.sv
`timescale 1ns / 1ps

module chaotic_lsb_watermark_embed_tb;

    import clwe_pkg::*;

    localparam int IMG = 65536;
    localparam int ITEMS = 1550;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_EMBED_STEPS = 1500;

    typedef struct packed {
        bit       st;
        bit [7:0] rd;
    } image_reply_t;

    class watermark_scoreboard;
        bit [7:0]     pixels[IMG];
        bit           marked[IMG];
        bit [23:0]    x;
        bit [23:0]    seed;
        bit [16:0]    span;
        bit [15:0]    tries_max;
        image_reply_t due_results[$];
        int           errors;

        function new();
            seed = SEED_RESET;
            span = LENGTH_RESET;
            tries_max = RETRY_RESET;
            x = SEED_RESET;
            errors = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SEED: seed = data[23:0];
                REG_LENGTH: span = data[16:0];
                REG_RETRY: tries_max = data[15:0];
                default: ;
            endcase
        endfunction

        function bit [23:0] next_x(bit [23:0] cur);
            bit [48:0] wide;
            bit [48:0] prod;
            wide = 49'(cur);
            prod = wide * ({24'd0, Q_ONE} - wide);
            if ((prod >> 22) > 49'hffffff)
                return 24'hffffff;
            return prod[45:22];
        endfunction

        // Searches a free position for each bit, most significant bit first. Without
        // commit it only reports the positions and the number of map steps.
        function bit walk_embed(input bit [7:0] val, input bit commit, output int spots[$],
                                output int steps);
            bit [23:0] cx;
            bit [40:0] prod;
            bit [16:0] pos;
            bit        taken[int];
            bit        found;
            cx = x;
            spots = {};
            steps = 0;
            for (int b = 7; b >= 0; b--)
            begin
                found = 1'b0;
                for (int t = 0; t < int'(tries_max) && !found; t++)
                begin
                    cx = next_x(cx);
                    steps++;
                    prod = 41'(span) * 41'(cx);
                    pos = prod[40:24];
                    if (pos < span && int'(pos) < IMG && !marked[pos[15:0]]
                        && !taken.exists(int'(pos)))
                    begin
                        found = 1'b1;
                        taken[int'(pos)] = 1'b1;
                        spots.push_back(int'(pos));
                        if (commit)
                        begin
                            pixels[pos[15:0]] = (pixels[pos[15:0]] & LSB_KEEP)
                                                | (val[b] ? LSB_BIT : 8'h00);
                            marked[pos[15:0]] = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    if (commit)
                        x = cx;
                    return 1'b1;
                end
            end
            if (commit)
                x = cx;
            return 1'b0;
        endfunction

        function bit apply_op(input bit [FUNC_W-1:0] op, input bit [15:0] idx,
                              input bit [7:0] val, output image_reply_t reply);
            int spots[$];
            int steps;
            reply = '0;
            case (op)
                OP_START:
                begin
                    x = seed;
                    marked = '{default: 1'b0};
                    return 1'b0;
                end
                OP_LOAD:
                begin
                    pixels[idx] = val;
                    return 1'b0;
                end
                OP_EMBED:
                begin
                    reply.st = walk_embed(val, 1'b1, spots, steps);
                    return 1'b1;
                end
                default:
                begin
                    reply.rd = pixels[idx];
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_input(bit [FUNC_W-1:0] op, bit [15:0] idx, bit [7:0] val);
            image_reply_t reply;
            if (apply_op(op, idx, val, reply))
                due_results.push_back(reply);
        endfunction

        function void check_result(bit [OUT_DATA_W-1:0] word);
            image_reply_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, word);
                return;
            end
            want = due_results.pop_front();
            if (word[7:0] != want.rd)
            begin
                errors++;
                $display("%0t: read_value mismatch, expected %h, actual %h",
                         $time, want.rd, word[7:0]);
            end
            if (word[8] != want.st)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.st, word[8]);
            end
            if (word[15:9] != 7'd0)
            begin
                errors++;
                $display("%0t: padding mismatch, expected 0, actual %h", $time, word[15:9]);
            end
        endfunction

        function int owed();
            return due_results.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    watermark_scoreboard tracker = new();
    watermark_scoreboard lookahead = new();

    bit          loaded[IMG];
    int          loaded_list[$];
    int          burst_left = 0;
    int          sent_count = 0;
    bit          hold_req = 1'b0;
    int unsigned cycle_count = 0;

    chaotic_lsb_watermark_embed #(
        .IMAGE_BYTES(IMG)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_input(s_tuser, s_tdata[15:0], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    // The receiver switches between stall patterns; a hold request parks it for a long stretch.
    initial
    begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(8, 150);
                end
                seg_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic issue(input logic [FUNC_W-1:0] op, input logic [15:0] idx,
                         input logic [7:0] val);
        image_reply_t scratch;
        int gap;
        void'(lookahead.apply_op(op, idx, val, scratch));
        if (op == OP_LOAD && !loaded[idx])
        begin
            loaded[idx] = 1'b1;
            loaded_list.push_back(int'(idx));
        end
        sent_count++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Image bytes that the embed will touch get loaded first, so no unwritten byte is used.
    task automatic embed_byte(input logic [7:0] val);
        int spots[$];
        int steps;
        void'(lookahead.walk_embed(val, 1'b0, spots, steps));
        if (steps > MAX_EMBED_STEPS)
            return;
        foreach (spots[i])
            if (!loaded[spots[i]])
                issue(OP_LOAD, spots[i][15:0], 8'($urandom_range(0, 255)));
        issue(OP_EMBED, 16'($urandom_range(0, 65535)), val);
    endtask

    task automatic read_any();
        issue(OP_READ, 16'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
              8'($urandom_range(0, 255)));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, data);
        lookahead.write_reg(idx, data);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.owed() != 0)
            @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int ops;
        int pick;
        int top;
        logic [23:0] seed_val;
        logic [23:0] span_val;
        logic [23:0] tries_val;

        rst_n = 1'b1;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_START;
        #1;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(OP_LOAD, 16'h0000, 8'h00);
        issue(OP_LOAD, 16'hffff, 8'hff);
        issue(OP_READ, 16'h0000, 8'hff);
        issue(OP_READ, 16'hffff, 8'h00);
        embed_byte(8'h5a);
        settle();

        // A tiny image: the first byte uses every position, the second runs out of them.
        set_reg(REG_SEED, 24'd1);
        set_reg(REG_LENGTH, 24'd8);
        set_reg(REG_RETRY, 24'd64);
        issue(OP_START, 16'h0000, 8'h00);
        embed_byte(8'hff);
        embed_byte(8'h00);
        read_any();
        settle();

        set_reg(REG_RETRY, 24'd0);
        embed_byte(8'h81);
        settle();

        set_reg(REG_RETRY, 24'd64);
        set_reg(REG_LENGTH, 24'd0);
        issue(OP_START, 16'hffff, 8'hff);
        embed_byte(8'h3c);
        settle();

        // Seed zero keeps the map at zero; positions past the store are retries too.
        set_reg(REG_LENGTH, 24'h1ffff);
        set_reg(REG_SEED, 24'd0);
        issue(OP_START, 16'h1234, 8'h56);
        embed_byte(8'hc3);
        settle();

        // The new seed waits for the next start; the midpoint seed saturates the map.
        set_reg(REG_SEED, 24'h800000);
        embed_byte(8'h7e);
        issue(OP_START, 16'h8000, 8'h80);
        embed_byte(8'h99);
        settle();

        set_reg(REG_SEED, 24'hffffff);
        set_reg(REG_LENGTH, 24'h10000);
        set_reg(REG_RETRY, 24'hffff);
        issue(OP_START, 16'h0f0f, 8'hf0);
        embed_byte(8'ha5);
        embed_byte(8'h0f);
        read_any();

        phase = 0;
        while (sent_count < ITEMS)
        begin
            settle();
            phase++;
            case ($urandom_range(0, 19))
                0: seed_val = 24'd1;
                1: seed_val = 24'hffffff;
                2: seed_val = 24'h800000;
                3: seed_val = 24'd0;
                default: seed_val = 24'($urandom_range(1, 24'hffffff));
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 11)
                span_val = 24'($urandom_range(16, 512));
            else if (pick < 16)
                span_val = 24'($urandom_range(513, 8192));
            else if (pick < 18)
                span_val = 24'h10000;
            else if (pick < 19)
            begin
                case ($urandom_range(0, 4))
                    0: span_val = 24'd0;
                    1: span_val = 24'd1;
                    2: span_val = 24'd2;
                    3: span_val = 24'hffff;
                    default: span_val = 24'h1ffff;
                endcase
            end
            else
                span_val = 24'($urandom_range(1, 65536));
            pick = $urandom_range(0, 19);
            if (pick < 14)
                tries_val = 24'($urandom_range(8, 256));
            else if (pick < 17)
                tries_val = 24'($urandom_range(1, 7));
            else if (pick < 19)
                tries_val = 24'($urandom_range(257, 4096));
            else
                tries_val = $urandom_range(0, 1) ? 24'hffff : 24'd0;
            set_reg(REG_SEED, seed_val);
            set_reg(REG_LENGTH, span_val);
            set_reg(REG_RETRY, tries_val);

            if (phase == 3)
            begin
                hold_req = 1'b1;
                burst_left = 40;
                repeat (24) read_any();
            end

            issue(OP_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            ops = $urandom_range(8, 48);
            repeat (ops)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    embed_byte(8'($urandom_range(0, 255)));
                else if (pick < 75)
                    read_any();
                else if (pick < 92)
                begin
                    if (span_val == 0 || $urandom_range(0, 1))
                        issue(OP_LOAD, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)));
                    else
                    begin
                        top = (span_val > 24'h10000) ? 65535 : int'(span_val) - 1;
                        issue(OP_LOAD, 16'($urandom_range(0, top)), 8'($urandom_range(0, 255)));
                    end
                end
                else
                    issue(OP_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
        end
        settle();

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: chaotic_lsb_watermark_embed.f
design/clwe_pkg.sv
design/clwe_front.sv
design/clwe_back.sv
design/chaotic_lsb_watermark_embed.sv
design/clwe_checker.sv
dv/chaotic_lsb_watermark_embed_tb.sv
